FILE: hdl/vector_length_normalize_unit_assert.svh
// Assertion macros for the vector length and normalize unit.
// Clock is clock, reset is reset (synchronous, active high).
`ifndef VECTOR_LENGTH_NORMALIZE_UNIT_ASSERT_SVH
`define VECTOR_LENGTH_NORMALIZE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define VLN_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define VLN_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: hdl/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Types and constants shared by the vector length and normalize unit.
// ----------------------------------------------------------------------------
package vln_pkg;

   localparam int DIV_W     = 32;
   localparam int UNIT_FRAC = 14;
   localparam logic [15:0] UNIT_ONE = 16'd16384;
   localparam logic [15:0] TOL_RESET = 16'd839;

   typedef struct packed {
      logic               func;
      logic signed [15:0] comp_x;
      logic signed [15:0] comp_y;
      logic signed [15:0] comp_z;
   } req_type;

   typedef struct packed {
      logic [15:0]        magnitude;
      logic signed [15:0] unit_x;
      logic signed [15:0] unit_y;
      logic signed [15:0] unit_z;
      logic               zero_vector;
      logic               no_converge;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_NEWT_GO,
      ST_NEWT_WAIT,
      ST_NEWT_MUL,
      ST_NEWT_CHK,
      ST_UNIT_GO,
      ST_UNIT_WAIT,
      ST_FINISH
   } vln_state_type;

endpackage

FILE: hdl/vln_div.sv
// ----------------------------------------------------------------------------
// vln_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vln_div
   import vln_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [DIV_W-1:0]   divisor,
   output logic [DIV_W-1:0]   quotient,
   output div_stat_type       status
);

   localparam int CW = $clog2(DIV_W);

   logic [DIV_W-1:0] rem_ff;
   logic [DIV_W-1:0] quo_ff;
   logic [DIV_W-1:0] dsr_ff;
   logic [CW-1:0]    cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DIV_W:0]   rem_sh;
   logic [DIV_W:0]   rem_in;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[DIV_W-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      rem_in = ge ? (rem_sh - {1'b0, dsr_ff}) : rem_sh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in[DIV_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], ge};
      end
   end

   // a zero divisor yields a zero quotient
   assign quotient = (dsr_ff == '0) ? '0 : quo_ff;
   assign status   = '{busy: busy_ff, done: done_ff};

endmodule

FILE: hdl/vector_length_normalize_unit.sv
// ----------------------------------------------------------------------------
// vector_length_normalize_unit
// Length and normalize of a signed Q4.12 3-vector by Newton square root.
// ----------------------------------------------------------------------------
// One item at a time. The squared length (Q8.24) is formed through one
// shared multiplier, then each Newton step x = (x + s/x)/2 runs as one
// divider start, a bit-serial division, an update once the division is
// done, one square and one tolerance check. Up to MAX_ITERATIONS steps
// run. A normalize item that is not a zero vector then runs the three
// component divisions in the same divider. The divider therefore sets how
// long an item takes; the result is then loaded into the result register.
// req_ready is high only while idle, so the next item is taken at the
// earliest in the cycle after the result is loaded; a finished item waits
// in the result register while the next item is taken. The tolerance
// register may be written at any time the unit is idle and is read live.
// ----------------------------------------------------------------------------
module vector_length_normalize_unit
   import vln_pkg::*;
#(
   parameter int MAX_ITERATIONS = 32,
   parameter int FRACTION_BITS  = 12
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_item,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_item,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int IW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

   vln_state_type state_ff, state_in;

   logic [15:0]        tol_ff;
   req_type            req_ff;
   logic [31:0]        s_ff;
   logic [31:0]        r_ff;
   logic [63:0]        prod_ff;
   logic [IW-1:0]      iter_ff;
   logic [1:0]         step_ff;
   logic               met_ff;
   logic               zero_ff;
   logic signed [15:0] unit_ff [3];
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   // datapath helpers
   logic signed [15:0] comp_sel;
   logic [15:0]        comp_abs;
   logic [31:0]        mul_a;
   logic [63:0]        diff;
   logic               met_now;
   logic               last_iter;
   logic               do_norm;
   logic [32:0]        r_sum;
   logic [31:0]        unit_q;
   logic [15:0]        unit_sat;
   logic [15:0]        mag_sat;

   // result checks
   logic               rsp_units_zero;
   logic               rsp_unit_x_ok;

   // divider hookup
   logic               div_start;
   logic [31:0]        div_dividend;
   logic [31:0]        div_quotient;
   div_stat_type       div_stat;

   // tolerance register, always writable
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_data;
      end
   end

   // pick the component the current step works on
   always_comb begin
      unique case (step_ff)
         2'd0:    comp_sel = req_ff.comp_x;
         2'd1:    comp_sel = req_ff.comp_y;
         default: comp_sel = req_ff.comp_z;
      endcase
      comp_abs = comp_sel[15] ? 16'(-comp_sel) : comp_sel;
   end

   always_comb begin
      diff      = (prod_ff > {32'd0, s_ff}) ? (prod_ff - {32'd0, s_ff})
                                            : ({32'd0, s_ff} - prod_ff);
      met_now   = diff < {48'd0, tol_ff};
      last_iter = iter_ff == IW'(MAX_ITERATIONS - 1);
      do_norm   = req_ff.func && !zero_ff;
      r_sum     = {1'b0, r_ff} + {1'b0, div_quotient};
      unit_q    = div_quotient;
      unit_sat  = (unit_q > {16'd0, UNIT_ONE}) ? UNIT_ONE : unit_q[15:0];
      mag_sat   = (r_ff[31:16] != 16'd0) ? 16'hFFFF : r_ff[15:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_SQ_MUL;
         ST_SQ_MUL:    state_in = ST_SQ_ACC;
         ST_SQ_ACC:    state_in = (step_ff == 2'd2) ? ST_NEWT_GO : ST_SQ_MUL;
         ST_NEWT_GO:   state_in = ST_NEWT_WAIT;
         ST_NEWT_WAIT: if (div_stat.done) state_in = ST_NEWT_MUL;
         ST_NEWT_MUL:  state_in = ST_NEWT_CHK;
         ST_NEWT_CHK: begin
            if (met_now || last_iter) begin
               state_in = do_norm ? ST_UNIT_GO : ST_FINISH;
            end else begin
               state_in = ST_NEWT_GO;
            end
         end
         ST_UNIT_GO:   state_in = ST_UNIT_WAIT;
         ST_UNIT_WAIT: begin
            if (div_stat.done) begin
               state_in = (step_ff == 2'd2) ? ST_FINISH : ST_UNIT_GO;
            end
         end
         ST_FINISH:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready    = state_ff == ST_IDLE;
      div_start    = (state_ff == ST_NEWT_GO) || (state_ff == ST_UNIT_GO);
      div_dividend = (state_ff == ST_UNIT_GO) ? {2'b00, comp_abs, 14'd0} : s_ff;
      mul_a        = (state_ff == ST_NEWT_MUL) ? r_ff : {16'd0, comp_abs};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: hold the item, accumulate, iterate
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            req_ff     <= req_item;
            s_ff       <= '0;
            r_ff       <= 32'd1 << FRACTION_BITS;
            iter_ff    <= '0;
            step_ff    <= '0;
            met_ff     <= 1'b0;
            unit_ff[0] <= '0;
            unit_ff[1] <= '0;
            unit_ff[2] <= '0;
         end
         ST_SQ_MUL:  prod_ff <= mul_a * mul_a;
         ST_SQ_ACC: begin
            s_ff    <= s_ff + prod_ff[31:0];
            step_ff <= (step_ff == 2'd2) ? 2'd0 : step_ff + 2'd1;
         end
         ST_NEWT_GO: begin
            // squared length is final by now
            zero_ff <= s_ff < {16'd0, tol_ff};
         end
         ST_NEWT_WAIT: if (div_stat.done) r_ff <= r_sum[32:1];
         ST_NEWT_MUL:  prod_ff <= mul_a * mul_a;
         ST_NEWT_CHK: begin
            met_ff  <= met_now;
            iter_ff <= iter_ff + 1'b1;
         end
         ST_UNIT_WAIT: begin
            if (div_stat.done) begin
               unit_ff[step_ff] <= comp_sel[15] ? 16'(-unit_sat) : unit_sat;
               step_ff          <= step_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // result register, frees the datapath from the consumer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff.magnitude   <= mag_sat;
         rsp_ff.unit_x      <= unit_ff[0];
         rsp_ff.unit_y      <= unit_ff[1];
         rsp_ff.unit_z      <= unit_ff[2];
         rsp_ff.zero_vector <= zero_ff;
         rsp_ff.no_converge <= !met_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   vln_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (r_ff),
      .quotient (div_quotient),
      .status   (div_stat)
   );

   assign rsp_units_zero = rsp_item.unit_x == 16'sd0 && rsp_item.unit_y == 16'sd0
                           && rsp_item.unit_z == 16'sd0;
   assign rsp_unit_x_ok  = rsp_item.unit_x >= -16'sd16384 && rsp_item.unit_x <= 16'sd16384;

`include "vector_length_normalize_unit_assert.svh"

   // zero vector gives zero unit components
   `VLN_ASSERT_SAME(a_zero_units, rsp_valid && rsp_item.zero_vector, rsp_units_zero)
   // the divider is never restarted mid-division
   `VLN_ASSERT_SAME(a_div_free, div_start, !div_stat.busy)
   // an accepted item makes the unit busy
   `VLN_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // the x unit component never exceeds one in magnitude
   `VLN_ASSERT_SAME(a_unit_range, rsp_valid, rsp_unit_x_ok)

endmodule
